// ----- rtl/bccc_pkg.sv -----
// shared types, constants and the coin value table for the bounded coin change counter
// no dependencies
package bccc_pkg;

  localparam int FIELD_W   = 10;
  localparam int NUM_COINS = 6;
  localparam int MAX_SUM   = 1023;
  localparam int DEPTH     = MAX_SUM + 1;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int WAYS_W    = 32;
  localparam int ACC_W     = WAYS_W + FIELD_W;
  localparam int COIN_W    = 7;
  localparam int K_W       = 3;
  localparam int IN_W      = 72;
  localparam int OUT_W     = 40;

  localparam logic [K_W-1:0] LAST_COIN = K_W'(NUM_COINS - 1);

  typedef logic [NUM_COINS-1:0][FIELD_W-1:0] count_vec_t;

  // one table entry per cycle from the sequencer to the accumulator while the sequencer runs
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              tail_en;
    logic              init;
    logic              bank;
    logic              hit;
    logic [ADDR_W-1:0] head;
    logic [ADDR_W-1:0] tail;
  } op_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [ADDR_W-1:0] addr;
    logic [WAYS_W-1:0] data;
  } wr_t;

  function automatic logic [COIN_W-1:0] coin_val(input logic [K_W-1:0] k);
    logic [COIN_W-1:0] v;
    case (k)
      3'd0:    v = 7'd2;
      3'd1:    v = 7'd5;
      3'd2:    v = 7'd10;
      3'd3:    v = 7'd20;
      3'd4:    v = 7'd50;
      3'd5:    v = 7'd100;
      default: v = 7'd100;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/bccc_ram.sv -----
// ways table storage: one write port, two registered read ports
// depends on bccc_pkg
module bccc_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [bccc_pkg::ADDR_W-1:0] waddr,
  input  logic [bccc_pkg::WAYS_W-1:0] wdata,
  input  logic [bccc_pkg::ADDR_W-1:0] raddr0,
  input  logic [bccc_pkg::ADDR_W-1:0] raddr1,
  output logic [bccc_pkg::WAYS_W-1:0] rdata0,
  output logic [bccc_pkg::WAYS_W-1:0] rdata1
);
  import bccc_pkg::*;

  logic [WAYS_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- rtl/bccc_seq.sv -----
// query sequencer: walks each coin's residue chains and issues table reads
// depends on bccc_pkg
module bccc_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [bccc_pkg::FIELD_W-1:0] in_target,
  input  bccc_pkg::count_vec_t         in_counts,
  input  logic                         out_free,
  output logic                         idle,
  output logic                         done,
  output bccc_pkg::op_t                op
);
  import bccc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RUN   = 5'b00010,
    S_GAP   = 5'b00100,
    S_FLUSH = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [ADDR_W-1:0]  target;
  count_vec_t         counts;
  logic [K_W-1:0]     k;
  logic [COIN_W-1:0]  r;
  logic [ADDR_W-1:0]  s;
  logic [ADDR_W-1:0]  tp;
  logic [FIELD_W-1:0] m;

  logic [COIN_W-1:0]  v;
  logic [FIELD_W-1:0] cnt;
  logic               tail_en;
  logic [ADDR_W:0]    s_nx;
  logic [COIN_W-1:0]  r_nx;
  logic               end_chain;
  logic               end_pass;

  assign v         = coin_val(k);
  assign cnt       = counts[k];
  assign tail_en   = (m == cnt);
  assign s_nx      = {1'b0, s} + (ADDR_W+1)'(v);
  assign r_nx      = r + COIN_W'(1);
  assign end_chain = s_nx > {1'b0, target};
  assign end_pass  = (r_nx == v) || (ADDR_W'(r_nx) > target);

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE) && out_free;

  always_comb begin
    op.valid   = (state == S_RUN);
    op.first   = (s == ADDR_W'(r));
    op.tail_en = tail_en;
    op.init    = (k == '0);
    op.bank    = ~k[0];
    op.hit     = (k == LAST_COIN) && (s == target);
    op.head    = s;
    op.tail    = tp;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_RUN;
      S_RUN:   if (end_chain && end_pass) state_next = (k == LAST_COIN) ? S_FLUSH : S_GAP;
      S_GAP:   state_next = S_RUN;
      S_FLUSH: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      target <= ADDR_W'(in_target);
      counts <= in_counts;
      k      <= '0;
      r      <= '0;
      s      <= '0;
      tp     <= '0;
      m      <= '0;
    end else if (state == S_RUN) begin
      if (end_chain) begin
        if (end_pass) begin
          k <= k + K_W'(1);
          r <= '0;
          s <= '0;
          tp <= '0;
        end else begin
          r  <= r_nx;
          s  <= ADDR_W'(r_nx);
          tp <= ADDR_W'(r_nx);
        end
        m <= '0;
      end else begin
        s <= s_nx[ADDR_W-1:0];
        if (tail_en) begin
          tp <= tp + ADDR_W'(v);
        end else begin
          m <= m + FIELD_W'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/bccc_acc.sv -----
// sliding window accumulator: new entry = old entry + window of older entries, saturated
// depends on bccc_pkg
module bccc_acc (
  input  logic                        clk,
  input  logic                        rst,
  input  bccc_pkg::op_t               op,
  input  logic [bccc_pkg::WAYS_W-1:0] rd_a0,
  input  logic [bccc_pkg::WAYS_W-1:0] rd_a1,
  input  logic [bccc_pkg::WAYS_W-1:0] rd_b0,
  input  logic [bccc_pkg::WAYS_W-1:0] rd_b1,
  output bccc_pkg::wr_t               wr,
  output logic [bccc_pkg::WAYS_W-1:0] ways,
  output logic                        overflow
);
  import bccc_pkg::*;

  op_t               op_q;
  logic [ACC_W-1:0]  w;
  logic [WAYS_W-1:0] old_s;
  logic [WAYS_W-1:0] old_t;
  logic [ACC_W-1:0]  w_cur;
  logic [ACC_W-1:0]  total;
  logic [ACC_W-1:0]  w_next;
  logic              sat;
  logic [WAYS_W-1:0] new_val;
  logic              clear;

  always_comb begin
    if (op_q.init) begin
      old_s = (op_q.head == '0) ? WAYS_W'(1) : '0;
      old_t = (op_q.tail == '0) ? WAYS_W'(1) : '0;
    end else begin
      old_s = op_q.bank ? rd_b0 : rd_a0;
      old_t = op_q.bank ? rd_b1 : rd_a1;
    end
    w_cur   = op_q.first ? '0 : w;
    total   = ACC_W'(old_s) + w_cur;
    sat     = (total[ACC_W-1:WAYS_W] != '0);
    new_val = sat ? '1 : total[WAYS_W-1:0];
    w_next  = total - (op_q.tail_en ? ACC_W'(old_t) : '0);
    clear   = op_q.init && op_q.first && (op_q.head == '0);
  end

  assign wr.en   = op_q.valid;
  assign wr.bank = op_q.bank;
  assign wr.addr = op_q.head;
  assign wr.data = new_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q.valid <= 1'b0;
    end else begin
      op_q.valid <= op.valid;
    end
    op_q.first   <= op.first;
    op_q.tail_en <= op.tail_en;
    op_q.init    <= op.init;
    op_q.bank    <= op.bank;
    op_q.hit     <= op.hit;
    op_q.head    <= op.head;
    op_q.tail    <= op.tail;
  end

  always_ff @(posedge clk) begin
    if (op_q.valid) begin
      w        <= w_next;
      overflow <= (clear ? 1'b0 : overflow) | sat;
      if (op_q.hit) begin
        ways <= new_val;
      end
    end
  end

endmodule

// ----- rtl/bounded_coin_change_counter_unit.sv -----
// throughput: one query at a time, a new one is taken only after the last result, one table entry per cycle per coin
//   pass, bounded by the single write port of the ways table memories
// reset: rst synchronous, active high; clears control and handshake state, the tables need none
// top level of the bounded coin change counter; depends on bccc_pkg, bccc_ram, bccc_seq, bccc_acc
module bounded_coin_change_counter_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // target_sum, count_two, count_five, count_ten, count_twenty, count_fifty,
  // count_hundred, 2 zero bits
  input  logic [bccc_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // ways, overflow, 7 zero bits
  output logic [bccc_pkg::OUT_W-1:0] m_tdata
);
  import bccc_pkg::*;

  count_vec_t        counts;
  op_t               op;
  wr_t               wr;
  logic              idle;
  logic              done;
  logic              out_free;
  logic [WAYS_W-1:0] rd_a0, rd_a1, rd_b0, rd_b1;
  logic [WAYS_W-1:0] ways;
  logic              overflow;

  always_comb begin
    for (int i = 0; i < NUM_COINS; i++) begin
      counts[i] = s_tdata[FIELD_W*(i+1) +: FIELD_W];
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = idle;

  bccc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_target (s_tdata[FIELD_W-1:0]),
    .in_counts (counts),
    .out_free  (out_free),
    .idle      (idle),
    .done      (done),
    .op        (op)
  );

  bccc_ram u_ram_a (
    .clk    (clk),
    .we     (wr.en && wr.bank),
    .waddr  (wr.addr),
    .wdata  (wr.data),
    .raddr0 (op.head),
    .raddr1 (op.tail),
    .rdata0 (rd_a0),
    .rdata1 (rd_a1)
  );

  bccc_ram u_ram_b (
    .clk    (clk),
    .we     (wr.en && !wr.bank),
    .waddr  (wr.addr),
    .wdata  (wr.data),
    .raddr0 (op.head),
    .raddr1 (op.tail),
    .rdata0 (rd_b0),
    .rdata1 (rd_b1)
  );

  bccc_acc u_acc (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .rd_a0    (rd_a0),
    .rd_a1    (rd_a1),
    .rd_b0    (rd_b0),
    .rd_b1    (rd_b1),
    .wr       (wr),
    .ways     (ways),
    .overflow (overflow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {(OUT_W-WAYS_W-1)'(0), overflow, ways};
    end
  end

endmodule

// ----- rtl/bccc_checker.sv -----
// port-level checks for the bounded coin change counter, bound to the top level
// depends on bccc_pkg and bounded_coin_change_counter_unit
module bccc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [bccc_pkg::IN_W-1:0]  s_tdata,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [bccc_pkg::OUT_W-1:0] m_tdata
);
  import bccc_pkg::*;

  // busy right after taking a query
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still ready after accepting a query");

  // no result in the cycle right after a query is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared too early");

  // coming back to idle always presents a result
  a_idle_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(s_tready) && !$past(rst) |-> m_tvalid)
    else $error("returned to idle without a result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_W-1:WAYS_W+1] == '0)
    else $error("result padding not zero");

endmodule

bind bounded_coin_change_counter_unit bccc_checker u_bccc_checker (.*);
